// File: rtl/tmps_pkg.sv
// ----------------------------------------------------------------------------
// Triangle maximum path sum: shared definitions
// Widths, limits and the command record that passes from the front end to
// the back end through the command queue.
// ----------------------------------------------------------------------------
package tmps_pkg;

  // Largest number of rows that the row buffer holds.
  localparam int MAX_ROWS = 128;

  // Index width for rows, columns and row buffer addresses.
  localparam int IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // Entry and sum widths.
  localparam int VALUE_W = 8;
  localparam int SUM_W   = 16;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [IDX_W-1:0] LAST_ROW = IDX_W'(MAX_ROWS - 1);

  // Depth of the command queue between front end and back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // One classified entry, ready for the back end.
  typedef struct packed {
    logic [VALUE_W-1:0] value;     // triangle number
    logic               last;      // final entry of the triangle
    logic [IDX_W-1:0]   col;       // column, also the row buffer address
    logic               apex;      // row zero: no parent
    logic               is_left;   // column zero: left edge, or the apex
    logic               at_right;  // column equals row: no parent straight above
  } cmd_t;

endpackage

// File: rtl/tmps_front.sv
// ----------------------------------------------------------------------------
// Triangle maximum path sum: front end
// Accepts entries, tracks the row and column of each one and classifies it
// by its place in the triangle before handing it to the command queue.
// ----------------------------------------------------------------------------
module tmps_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [tmps_pkg::VALUE_W-1:0]  in_entry_value,
  input  logic                          in_is_last,
  input  logic                          queue_full,
  output logic                          push,
  output tmps_pkg::cmd_t                push_cmd
);

  logic [tmps_pkg::IDX_W-1:0] row_r, row_nxt;
  logic [tmps_pkg::IDX_W-1:0] col_r, col_nxt;
  logic                       at_right;

  // A request is taken whenever the queue has room.
  assign push     = in_valid && !queue_full;
  assign at_right = (col_r == row_r);

  // Classify the entry by its position.
  always_comb begin
    push_cmd.value    = in_entry_value;
    push_cmd.last     = in_is_last;
    push_cmd.col      = col_r;
    push_cmd.apex     = (row_r == '0);
    push_cmd.is_left  = (col_r == '0);
    push_cmd.at_right = at_right;
  end

  // Step through the triangle; the row index holds at the last row.
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (push) begin
      if (in_is_last) begin
        row_nxt = '0;
        col_nxt = '0;
      end else if (at_right) begin
        col_nxt = '0;
        row_nxt = (row_r == tmps_pkg::LAST_ROW) ? row_r
                                                : row_r + tmps_pkg::IDX_W'(1);
      end else begin
        col_nxt = col_r + tmps_pkg::IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

endmodule

// File: rtl/tmps_queue.sv
// ----------------------------------------------------------------------------
// Triangle maximum path sum: command queue
// A two-entry queue of classified entries that lets the front end and the
// back end stall independently.
// ----------------------------------------------------------------------------
module tmps_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tmps_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           q_valid,
  output tmps_pkg::cmd_t q_cmd
);

  tmps_pkg::cmd_t                slot_r [tmps_pkg::QUEUE_DEPTH];
  logic [tmps_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [tmps_pkg::QCNT_W-1:0]   count_r, count_nxt;

  assign full    = (count_r == tmps_pkg::QCNT_W'(tmps_pkg::QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = slot_r[rd_ptr_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + tmps_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - tmps_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + tmps_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + tmps_pkg::QPTR_W'(1);
      end
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: rtl/tmps_back.sv
// ----------------------------------------------------------------------------
// Triangle maximum path sum: back end
// Reads the parent sum from the row buffer, adds the entry with saturation,
// writes the new sum back, keeps the row maximum and presents the result.
// ----------------------------------------------------------------------------
module tmps_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  tmps_pkg::cmd_t                q_cmd,
  output logic                          pop,
  output logic                          out_valid,
  output logic [tmps_pkg::SUM_W-1:0]    out_max_sum,
  input  logic                          out_stall
);

  // Row buffer: path sums of the most recent row, updated in place.
  logic [tmps_pkg::SUM_W-1:0] row_mem [tmps_pkg::MAX_ROWS];

  // Execute stage.
  logic                       s1_valid_r;
  tmps_pkg::cmd_t             s1_cmd_r;
  logic [tmps_pkg::SUM_W-1:0] rd_data_r;
  logic                       fwd_hit_r;
  logic [tmps_pkg::SUM_W-1:0] fwd_data_r;

  logic [tmps_pkg::SUM_W-1:0] left_parent_r, left_parent_nxt;
  logic [tmps_pkg::SUM_W-1:0] best_r, best_nxt;
  logic                       out_valid_r;
  logic [tmps_pkg::SUM_W-1:0] out_max_sum_r;

  logic [tmps_pkg::SUM_W-1:0] old_here;
  logic [tmps_pkg::SUM_W-1:0] parent;
  logic [tmps_pkg::SUM_W:0]   sum_wide;
  logic [tmps_pkg::SUM_W-1:0] sum;
  logic                       retire;
  logic                       load;

  // An entry retires unless it carries a result and the output is occupied.
  assign retire = s1_valid_r && (!s1_cmd_r.last || !out_valid_r || !out_stall);
  assign load   = q_valid && (!s1_valid_r || retire);
  assign pop    = load;

  // Sum straight above; the entry just retired is forwarded when it wrote
  // the same address in the cycle of the read.
  always_comb begin
    if (s1_cmd_r.at_right) begin
      old_here = '0;
    end else if (fwd_hit_r) begin
      old_here = fwd_data_r;
    end else begin
      old_here = rd_data_r;
    end
  end

  // Parent choice by position, then a saturating add.
  always_comb begin
    if (s1_cmd_r.apex) begin
      parent = '0;
    end else if (s1_cmd_r.is_left) begin
      parent = old_here;
    end else if (s1_cmd_r.at_right) begin
      parent = left_parent_r;
    end else begin
      parent = (left_parent_r > old_here) ? left_parent_r : old_here;
    end
    sum_wide = {1'b0, parent} + (tmps_pkg::SUM_W + 1)'(s1_cmd_r.value);
    sum      = sum_wide[tmps_pkg::SUM_W] ? tmps_pkg::SUM_MAX
                                         : sum_wide[tmps_pkg::SUM_W-1:0];
  end

  // Running row state after this entry.
  always_comb begin
    best_nxt        = (s1_cmd_r.is_left || (sum > best_r)) ? sum : best_r;
    left_parent_nxt = (s1_cmd_r.last || s1_cmd_r.at_right) ? '0 : old_here;
  end

  // Row buffer write on retire, registered read on load.
  always_ff @(posedge clk) begin
    if (retire) begin
      row_mem[s1_cmd_r.col] <= sum;
    end
    if (load) begin
      rd_data_r <= row_mem[q_cmd.col];
    end
  end

  // Stage payload and bypass data.
  always_ff @(posedge clk) begin
    if (load) begin
      s1_cmd_r   <= q_cmd;
      fwd_hit_r  <= retire && (s1_cmd_r.col == q_cmd.col);
      fwd_data_r <= sum;
    end
    if (retire && s1_cmd_r.last) begin
      out_max_sum_r <= best_nxt;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      left_parent_r <= '0;
      best_r        <= '0;
    end else begin
      if (load) begin
        s1_valid_r <= 1'b1;
      end else if (retire) begin
        s1_valid_r <= 1'b0;
      end
      if (retire) begin
        left_parent_r <= left_parent_nxt;
        best_r        <= s1_cmd_r.last ? '0 : best_nxt;
      end
      if (retire && s1_cmd_r.last) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_max_sum = out_max_sum_r;

  // A retiring final entry always leaves a result behind.
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (retire && s1_cmd_r.last) |=> out_valid_r)
    else $error("final entry retired without a result");

  // A saturating sum never falls below the entry itself.
  a_sum_covers_value: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (sum >= tmps_pkg::SUM_W'(s1_cmd_r.value)))
    else $error("path sum below entry value");

  // The left parent is cleared at the end of every row and triangle.
  a_left_parent_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (retire && (s1_cmd_r.last || s1_cmd_r.at_right)) |=> (left_parent_r == '0))
    else $error("left parent sum not cleared at row end");

  // A new request only enters the stage when the previous one leaves.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !retire) |=> (s1_valid_r && $stable(s1_cmd_r)))
    else $error("stalled entry lost from execute stage");

endmodule

// File: rtl/triangle_max_path_sum.sv
// ----------------------------------------------------------------------------
// Triangle maximum path sum: top level
// Takes the numbers of a triangle in row order from the apex, one request
// per cycle while in_stall is low, and on the request flagged last returns
// the largest apex-to-entry path sum of the final (possibly partial) row,
// saturated at 65535. It then starts over at the apex. One entry is taken
// every cycle when the output is not stalled; the rate is set by the single
// row buffer, which is read and written once per entry, with the sum of the
// previous entry forwarded when both touch the same address. After its last
// entry is accepted, a result passes through the command queue, the execute
// stage and the output register. Beyond the deepest row each further row
// reuses the last row's length. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module triangle_max_path_sum (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tmps_pkg::VALUE_W-1:0]  in_entry_value,
  input  logic                          in_is_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tmps_pkg::SUM_W-1:0]    out_max_sum
);

  logic           queue_full;
  logic           push;
  tmps_pkg::cmd_t push_cmd;
  logic           pop;
  logic           q_valid;
  tmps_pkg::cmd_t q_cmd;

  assign in_stall = queue_full;

  // Position tracking and classification.
  tmps_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_entry_value (in_entry_value),
    .in_is_last     (in_is_last),
    .queue_full     (queue_full),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  // Decoupling queue.
  tmps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (queue_full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // Row buffer, sum and result.
  tmps_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_max_sum (out_max_sum),
    .out_stall   (out_stall)
  );

endmodule
